FILE: design/cvi_pkg.sv
// cvi_pkg: shared types, codes and fixed widths of the cosine top-k vector index.
// Depends on nothing; imported by cvi_div, cvi_topk_cell, the top level and cvi_checker.
`default_nettype none
package cvi_pkg;

  localparam int ELEM_W  = 16;
  localparam int KEY_W   = 16;
  localparam int SCORE_W = 16;
  localparam int LIVE_W  = 11;
  localparam int KREQ_W  = 5;
  localparam int CFG_W   = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int QBITS   = 15;
  localparam int DIM_RESET = 128;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NORES    = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [KEY_W-1:0]          key;
    logic                      pres;
  } cvi_ent_t;

  typedef struct packed {
    logic init;
    logic ins;
    logic shift;
  } cvi_cellctl_t;

endpackage
`default_nettype wire

FILE: design/cvi_ram.sv
// cvi_ram: generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module cvi_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [W-1:0]                             wdata,
  output logic      [W-1:0]                             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: design/cvi_isqrt.sv
// cvi_isqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on nothing.
`default_nettype none
module cvi_isqrt #(
  parameter int RW = 19
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] x,
  output logic                 done,
  output logic      [RW-1:0]   root
);
  localparam int CNW = $clog2(RW + 1);

  logic [2*RW-1:0] x_r;
  logic [RW+2:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNW-1:0]  cnt_r;
  logic            busy_r, done_r;
  logic [RW+2:0]   rem_sh, trial;
  logic            ge;

  assign rem_sh = {rem_r[RW:0], x_r[2*RW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNW'(RW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= RW'({root_r, ge});
        x_r    <= {x_r[2*RW-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

FILE: design/cvi_div.sv
// cvi_div: restoring divider for the Q1.15 score, one quotient bit per cycle.
// Depends on cvi_pkg for the fraction width; flags saturation when mag >= den.
`default_nettype none
module cvi_div
  import cvi_pkg::*;
#(
  parameter int MAGW = 38,
  parameter int DENW = 38
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [MAGW-1:0] mag,
  input  wire logic [DENW-1:0] den,
  output logic                 done,
  output logic                 sat,
  output logic      [QBITS-1:0] q
);
  localparam int EW  = MAGW + DENW;
  localparam int CNW = $clog2(QBITS + 1);

  logic [DENW-1:0]  rem_r, den_r;
  logic [QBITS-1:0] q_r;
  logic [CNW-1:0]   cnt_r;
  logic             busy_r, done_r, sat_r;
  logic [DENW:0]    r2;
  logic             ge;

  assign r2 = {rem_r, 1'b0};
  assign ge = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        rem_r <= DENW'(mag);
        q_r   <= '0;
        cnt_r <= CNW'(QBITS);
        sat_r <= (EW'(mag) >= EW'(den));
        if (EW'(mag) >= EW'(den)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? DENW'(r2 - {1'b0, den_r}) : DENW'(r2);
        q_r   <= {q_r[QBITS-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign sat  = sat_r;
  assign q    = q_r;
endmodule
`default_nettype wire

FILE: design/cvi_topk_cell.sv
// cvi_topk_cell: one rank of the sorted top-k chain.
// Depends on cvi_pkg; takes its upper neighbor on insert, lower neighbor on shift.
`default_nettype none
module cvi_topk_cell
  import cvi_pkg::*;
(
  input  wire logic                      clk,
  input  wire cvi_cellctl_t              ctl,
  input  wire logic signed [SCORE_W-1:0] cand_score,
  input  wire logic [KEY_W-1:0]          cand_key,
  input  wire cvi_ent_t                  up_ent,
  input  wire logic                      up_gt,
  input  wire cvi_ent_t                  dn_ent,
  output cvi_ent_t                       ent,
  output logic                           gt
);
  cvi_ent_t ent_r;

  // strict greater: on a tie the entry already held keeps its rank
  assign gt = (cand_score > ent_r.score);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      ent_r.score <= SCORE_MIN;
      ent_r.key   <= '0;
      ent_r.pres  <= 1'b0;
    end else if (ctl.shift) begin
      ent_r <= dn_ent;
    end else if (ctl.ins && gt) begin
      if (up_gt) begin
        ent_r <= up_ent;
      end else begin
        ent_r.score <= cand_score;
        ent_r.key   <= cand_key;
        ent_r.pres  <= 1'b1;
      end
    end
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

FILE: design/cosine_topk_vector_index.sv
// Cosine top-k vector index: a keyed vector store searched by a full cosine scan.
// Depends on cvi_pkg, cvi_ram, cvi_isqrt, cvi_div and cvi_topk_cell.
//
// Operation per item:
//   non-last add or query element: no result; count: result in the next cycle.
//   last add element: result, then a zero-fill pass over the rest of the entry in the vector RAM.
//   remove: key search over the metadata RAM, states S_RM_RD and S_RM_CK per slot examined.
//   query: the query norm root, then per live slot the entry norm root, the dot
//   product over the vector RAM port and the divider; removed slots pass through
//   S_META and S_MWAIT only; then one result per cycle for the n ranks.
//   RW, the root width, is half the norm width, rounded up.
// Reset clears control state only; no clearing pass; results cannot be stalled.
`default_nettype none
module cosine_topk_vector_index
  import cvi_pkg::*;
#(
  parameter int DIM      = 128,
  parameter int CAPACITY = 1024,
  parameter int KMAX     = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [CMD_W-1:0]          in_command,
  input  wire logic [KEY_W-1:0]          in_key,
  input  wire logic signed [ELEM_W-1:0]  in_element,
  input  wire logic                      in_last,
  input  wire logic [KREQ_W-1:0]         in_k_requested,
  output logic                           out_valid,
  output logic [STAT_W-1:0]              out_status,
  output logic [KEY_W-1:0]               out_match_key,
  output logic signed [SCORE_W-1:0]      out_score,
  output logic                           out_match_present,
  output logic [LIVE_W-1:0]              out_live_count,
  output logic                           out_last_result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_W-1:0]          cfg_data
);
  localparam int PW  = $clog2(DIM + 1);
  localparam int NW  = 31 + $clog2(DIM);
  localparam int AW  = NW + 1;
  localparam int RW  = (NW + 1) / 2;
  localparam int DW  = 2 * RW;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = $clog2(CAPACITY);
  localparam int VD  = CAPACITY * DIM;
  localparam int VAW = $clog2(VD);
  localparam int VBW = $clog2(VD + 1);
  localparam int QAW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KW  = $clog2(KMAX + 1);
  localparam int MW  = 1 + KEY_W + NW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_RM_RD  = 4'd2;
  localparam logic [3:0] S_RM_CK  = 4'd3;
  localparam logic [3:0] S_QSQRT  = 4'd4;
  localparam logic [3:0] S_META   = 4'd5;
  localparam logic [3:0] S_MWAIT  = 4'd6;
  localparam logic [3:0] S_ESQRT  = 4'd7;
  localparam logic [3:0] S_DOT    = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_DSTART = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_INS    = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  // control registers
  logic [3:0]       state_r, state_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [NW-1:0]    rn_r, rn_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    live_r, live_nxt;
  logic [VBW-1:0]   add_base_r, add_base_nxt;
  logic [CFG_W-1:0] dim_r;
  logic             v1_r, v1_nxt, v2_r, v2_nxt;
  logic             ov_r, ov_nxt;
  logic             olast_r, olast_nxt;

  // payload registers
  logic [PW-1:0]             fill_pos_r, fill_pos_nxt;
  logic [CW-1:0]             slot_r, slot_nxt;
  logic [VBW-1:0]            scan_base_r, scan_base_nxt;
  logic [KEY_W-1:0]          rm_key_r, rm_key_nxt;
  logic [KW-1:0]             n_r, n_nxt;
  logic [NW-1:0]             qnorm_r, qnorm_nxt;
  logic [PW-1:0]             qlen_r, qlen_nxt;
  logic [RW-1:0]             ra_r, ra_nxt, rb_r, rb_nxt;
  logic [KEY_W-1:0]          cur_key_r, cur_key_nxt;
  logic [PW-1:0]             e_r, e_nxt, e1_r, e1_nxt;
  logic signed [31:0]        prod_r, prod_nxt;
  logic signed [AW-1:0]      acc_r, acc_nxt;
  logic [DW-1:0]             den_r, den_nxt;
  logic [NW-1:0]             mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [SCORE_W-1:0] cand_r, cand_nxt;
  logic [KW-1:0]             j_r, j_nxt;
  logic [STAT_W-1:0]         ost_r, ost_nxt;
  logic [KEY_W-1:0]          okey_r, okey_nxt;
  logic signed [SCORE_W-1:0] osc_r, osc_nxt;
  logic                      opres_r, opres_nxt;
  logic [CW-1:0]             olive_r, olive_nxt;

  // memories
  logic             vec_we, qb_we, mt_we;
  logic [VAW-1:0]   vec_addr;
  logic [QAW-1:0]   qb_addr;
  logic [SW-1:0]    mt_addr;
  logic [ELEM_W-1:0] vec_wd, vec_rd, qb_wd, qb_rd;
  logic [MW-1:0]    mt_wd, mt_rd;

  // root unit, shared by query and entry norms, and divider
  logic             sq_start, sq_done;
  logic [NW-1:0]    sq_in;
  logic [RW-1:0]    sq_root;
  logic             dv_start, dv_done, dv_sat;
  logic [QBITS-1:0] dv_q;

  // top-k chain
  cvi_cellctl_t     cell_ctl;
  cvi_ent_t         ent_w [KMAX];
  logic             gt_w [KMAX];
  cvi_ent_t         cand_ent, init_ent;

  // item decode
  logic             accept;
  logic [PW-1:0]    d_eff;
  logic             in_range, room;
  logic signed [31:0] sq32;
  logic [NW-1:0]    nrm_new;
  logic [PW-1:0]    np;
  logic [31:0]      n_calc;
  logic             mt_removed;
  logic [KEY_W-1:0] mt_key;
  logic [NW-1:0]    mt_norm;
  logic [SCORE_W-1:0] q16;
  logic signed [SCORE_W-1:0] div_score;
  logic [CW-1:0]    slot_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // effective dimension: register clamped to 1..DIM
  always_comb begin
    if (dim_r == '0) begin
      d_eff = PW'(1);
    end else if (32'(dim_r) > 32'(DIM)) begin
      d_eff = PW'(DIM);
    end else begin
      d_eff = PW'(dim_r);
    end
  end

  assign in_range = (pos_r < d_eff);
  assign room     = (used_r < CW'(CAPACITY));
  assign sq32     = in_element * in_element;
  assign nrm_new  = in_range ? (rn_r + NW'(sq32[30:0])) : rn_r;
  assign np       = in_range ? (pos_r + 1'b1) : pos_r;
  assign slot_inc = slot_r + 1'b1;

  // rank count: min(k_requested, KMAX, live)
  always_comb begin
    n_calc = 32'(in_k_requested);
    if (n_calc > 32'(KMAX)) begin
      n_calc = 32'(KMAX);
    end
    if (n_calc > 32'(live_r)) begin
      n_calc = 32'(live_r);
    end
  end

  assign mt_removed = mt_rd[MW-1];
  assign mt_key     = mt_rd[MW-2 -: KEY_W];
  assign mt_norm    = mt_rd[NW-1:0];

  // score from quotient: saturate on either side
  assign q16 = {1'b0, dv_q};
  always_comb begin
    if (neg_r) begin
      div_score = dv_sat ? SCORE_MIN : $signed(SCORE_W'(16'd0 - q16));
    end else begin
      div_score = dv_sat ? SCORE_MAX : $signed(q16);
    end
  end

  assign cand_ent.score = cand_r;
  assign cand_ent.key   = cur_key_r;
  assign cand_ent.pres  = 1'b1;
  assign init_ent.score = SCORE_MIN;
  assign init_ent.key   = '0;
  assign init_ent.pres  = 1'b0;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rn_nxt        = rn_r;
    used_nxt      = used_r;
    live_nxt      = live_r;
    add_base_nxt  = add_base_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    ov_nxt        = 1'b0;
    olast_nxt     = 1'b0;
    fill_pos_nxt  = fill_pos_r;
    slot_nxt      = slot_r;
    scan_base_nxt = scan_base_r;
    rm_key_nxt    = rm_key_r;
    n_nxt         = n_r;
    qnorm_nxt     = qnorm_r;
    qlen_nxt      = qlen_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    cur_key_nxt   = cur_key_r;
    e_nxt         = e_r;
    e1_nxt        = e1_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cand_nxt      = cand_r;
    j_nxt         = j_r;
    ost_nxt       = ST_OK;
    okey_nxt      = '0;
    osc_nxt       = '0;
    opres_nxt     = 1'b0;
    olive_nxt     = live_r;
    vec_we        = 1'b0;
    vec_addr      = VAW'(add_base_r + VBW'(pos_r));
    vec_wd        = in_element;
    qb_we         = 1'b0;
    qb_addr       = QAW'(pos_r);
    qb_wd         = in_element;
    mt_we         = 1'b0;
    mt_addr       = SW'(slot_r);
    mt_wd         = {1'b0, in_key, nrm_new};
    sq_start      = 1'b0;
    sq_in         = nrm_new;
    dv_start      = 1'b0;
    cell_ctl      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_COUNT: begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
            end
            CMD_REMOVE: begin
              rm_key_nxt = in_key;
              slot_nxt   = '0;
              state_nxt  = S_RM_RD;
            end
            CMD_ADD, CMD_QUERY: begin
              // store the element if it lies within the dimension and, for an add, there is room
              if (in_command == CMD_ADD) begin
                vec_we = in_range && room;
              end else begin
                qb_we = in_range;
              end
              if (!in_last) begin
                pos_nxt = np;
                rn_nxt  = nrm_new;
              end else begin
                pos_nxt = '0;
                rn_nxt  = '0;
                if (in_command == CMD_ADD) begin
                  ov_nxt    = 1'b1;
                  olast_nxt = 1'b1;
                  if (!room) begin
                    ost_nxt = ST_FULL;
                  end else begin
                    mt_we     = 1'b1;
                    mt_addr   = SW'(used_r);
                    live_nxt  = live_r + 1'b1;
                    olive_nxt = live_r + 1'b1;
                    if (np < PW'(DIM)) begin
                      fill_pos_nxt = np;
                      state_nxt    = S_FILL;
                    end else begin
                      used_nxt     = used_r + 1'b1;
                      add_base_nxt = add_base_r + VBW'(DIM);
                    end
                  end
                end else begin
                  if (n_calc == 32'd0) begin
                    ov_nxt    = 1'b1;
                    olast_nxt = 1'b1;
                    ost_nxt   = ST_NORES;
                  end else begin
                    n_nxt         = KW'(n_calc);
                    qnorm_nxt     = nrm_new;
                    qlen_nxt      = np;
                    cell_ctl.init = 1'b1;
                    sq_start      = 1'b1;
                    state_nxt     = S_QSQRT;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FILL: begin
        // zero the tail of the new entry so any later dimension reads zeros
        vec_we       = 1'b1;
        vec_addr     = VAW'(add_base_r + VBW'(fill_pos_r));
        vec_wd       = '0;
        fill_pos_nxt = fill_pos_r + 1'b1;
        if (fill_pos_r == PW'(DIM - 1)) begin
          used_nxt     = used_r + 1'b1;
          add_base_nxt = add_base_r + VBW'(DIM);
          state_nxt    = S_IDLE;
        end
      end

      S_RM_RD: begin
        if (slot_r == used_r) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          ost_nxt   = ST_NOTFOUND;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RM_CK;
        end
      end

      S_RM_CK: begin
        if (!mt_removed && (mt_key == rm_key_r)) begin
          // mark the first live match, keep its key and norm
          mt_we     = 1'b1;
          mt_wd     = {1'b1, mt_rd[MW-2:0]};
          live_nxt  = live_r - 1'b1;
          olive_nxt = live_r - 1'b1;
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          slot_nxt  = slot_inc;
          state_nxt = S_RM_RD;
        end
      end

      S_QSQRT: begin
        if (sq_done) begin
          ra_nxt        = sq_root;
          slot_nxt      = '0;
          scan_base_nxt = '0;
          state_nxt     = S_META;
        end
      end

      S_META: begin
        state_nxt = S_MWAIT;
      end

      S_MWAIT: begin
        if (mt_removed) begin
          slot_nxt      = slot_inc;
          scan_base_nxt = scan_base_r + VBW'(DIM);
          if (slot_inc == used_r) begin
            j_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_META;
          end
        end else begin
          cur_key_nxt = mt_key;
          if ((qnorm_r == '0) || (mt_norm == '0)) begin
            cand_nxt  = '0;
            state_nxt = S_INS;
          end else begin
            sq_start  = 1'b1;
            sq_in     = mt_norm;
            state_nxt = S_ESQRT;
          end
        end
      end

      S_ESQRT: begin
        if (sq_done) begin
          rb_nxt    = sq_root;
          e_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_DOT;
        end
      end

      S_DOT: begin
        // issue one element a cycle: RAM read, multiply, accumulate
        if (e_r < d_eff) begin
          vec_addr = VAW'(scan_base_r + VBW'(e_r));
          qb_addr  = QAW'(e_r);
          v1_nxt   = 1'b1;
          e1_nxt   = e_r;
          e_nxt    = e_r + 1'b1;
        end
        v2_nxt   = v1_r;
        prod_nxt = ((e1_r < qlen_r) ? $signed(qb_rd) : $signed(16'sd0)) * $signed(vec_rd);
        if (v2_r) begin
          acc_nxt = acc_r + AW'($signed(prod_r));
        end
        if (!(e_r < d_eff) && !v1_r && !v2_r) begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        den_nxt   = DW'(ra_r) * DW'(rb_r);
        neg_nxt   = acc_r[AW-1];
        mag_nxt   = acc_r[AW-1] ? NW'(-acc_r) : NW'(acc_r);
        state_nxt = S_DSTART;
      end

      S_DSTART: begin
        dv_start  = 1'b1;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (dv_done) begin
          cand_nxt  = div_score;
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        cell_ctl.ins  = 1'b1;
        slot_nxt      = slot_inc;
        scan_base_nxt = scan_base_r + VBW'(DIM);
        if (slot_inc == used_r) begin
          j_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_META;
        end
      end

      S_EMIT: begin
        // drain the chain from its head, one rank a cycle
        cell_ctl.shift = 1'b1;
        ov_nxt         = 1'b1;
        okey_nxt       = ent_w[0].key;
        osc_nxt        = ent_w[0].score;
        opres_nxt      = ent_w[0].pres;
        j_nxt          = j_r + 1'b1;
        if (j_r == KW'(n_r - 1'b1)) begin
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r      <= '0;
      rn_r       <= '0;
      used_r     <= '0;
      live_r     <= '0;
      add_base_r <= '0;
      dim_r      <= CFG_W'(DIM_RESET);
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      ov_r       <= 1'b0;
      olast_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      rn_r       <= rn_nxt;
      used_r     <= used_nxt;
      live_r     <= live_nxt;
      add_base_r <= add_base_nxt;
      v1_r       <= v1_nxt;
      v2_r       <= v2_nxt;
      ov_r       <= ov_nxt;
      olast_r    <= olast_nxt;
      if (cfg_valid && cfg_ready) begin
        dim_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_pos_r  <= fill_pos_nxt;
    slot_r      <= slot_nxt;
    scan_base_r <= scan_base_nxt;
    rm_key_r    <= rm_key_nxt;
    n_r         <= n_nxt;
    qnorm_r     <= qnorm_nxt;
    qlen_r      <= qlen_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    cur_key_r   <= cur_key_nxt;
    e_r         <= e_nxt;
    e1_r        <= e1_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    den_r       <= den_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    cand_r      <= cand_nxt;
    j_r         <= j_nxt;
    ost_r       <= ost_nxt;
    okey_r      <= okey_nxt;
    osc_r       <= osc_nxt;
    opres_r     <= opres_nxt;
    olive_r     <= olive_nxt;
  end

  cvi_ram #(.W(ELEM_W), .DEPTH(VD)) u_vec_ram (
    .clk(clk), .we(vec_we), .addr(vec_addr), .wdata(vec_wd), .rdata(vec_rd)
  );

  cvi_ram #(.W(ELEM_W), .DEPTH(DIM)) u_qbuf_ram (
    .clk(clk), .we(qb_we), .addr(qb_addr), .wdata(qb_wd), .rdata(qb_rd)
  );

  // metadata per slot: removed mark, key, squared norm
  cvi_ram #(.W(MW), .DEPTH(CAPACITY)) u_meta_ram (
    .clk(clk), .we(mt_we), .addr(mt_addr), .wdata(mt_wd), .rdata(mt_rd)
  );

  cvi_isqrt #(.RW(RW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(DW'(sq_in)),
    .done(sq_done), .root(sq_root)
  );

  cvi_div #(.MAGW(NW), .DENW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .mag(mag_r), .den(den_r),
    .done(dv_done), .sat(dv_sat), .q(dv_q)
  );

  for (genvar g = 0; g < KMAX; g++) begin : g_cell
    if (g == 0 && KMAX == 1) begin : g_only
      cvi_topk_cell u_cell (
        .clk(clk), .ctl(cell_ctl), .cand_score(cand_r), .cand_key(cur_key_r),
        .up_ent(cand_ent), .up_gt(1'b1), .dn_ent(init_ent),
        .ent(ent_w[g]), .gt(gt_w[g])
      );
    end else if (g == 0) begin : g_head
      cvi_topk_cell u_cell (
        .clk(clk), .ctl(cell_ctl), .cand_score(cand_r), .cand_key(cur_key_r),
        .up_ent(cand_ent), .up_gt(1'b1), .dn_ent(ent_w[g+1]),
        .ent(ent_w[g]), .gt(gt_w[g])
      );
    end else if (g == KMAX - 1) begin : g_tail
      cvi_topk_cell u_cell (
        .clk(clk), .ctl(cell_ctl), .cand_score(cand_r), .cand_key(cur_key_r),
        .up_ent(ent_w[g-1]), .up_gt(gt_w[g-1]), .dn_ent(init_ent),
        .ent(ent_w[g]), .gt(gt_w[g])
      );
    end else begin : g_mid
      cvi_topk_cell u_cell (
        .clk(clk), .ctl(cell_ctl), .cand_score(cand_r), .cand_key(cur_key_r),
        .up_ent(ent_w[g-1]), .up_gt(gt_w[g-1]), .dn_ent(ent_w[g+1]),
        .ent(ent_w[g]), .gt(gt_w[g])
      );
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_match_key     = okey_r;
  assign out_score         = osc_r;
  assign out_match_present = opres_r;
  assign out_live_count    = LIVE_W'(olive_r);
  assign out_last_result   = olast_r;
endmodule
`default_nettype wire

FILE: design/cvi_checker.sv
// cvi_checker: port-level assertions on the cosine top-k vector index, and its bind.
// Depends on cvi_pkg and on the top level's port list.
`default_nettype none
module cvi_checker
  import cvi_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [CMD_W-1:0]         in_command,
  input wire logic [KEY_W-1:0]         in_key,
  input wire logic signed [ELEM_W-1:0] in_element,
  input wire logic                     in_last,
  input wire logic [KREQ_W-1:0]        in_k_requested,
  input wire logic                     out_valid,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic [KEY_W-1:0]         out_match_key,
  input wire logic signed [SCORE_W-1:0] out_score,
  input wire logic                     out_match_present,
  input wire logic [LIVE_W-1:0]        out_live_count,
  input wire logic                     out_last_result,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready,
  input wire logic [CFG_W-1:0]         cfg_data
);
  a_count_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_COUNT) |=> (out_valid && out_last_result))
    else $error("count item did not answer in the next cycle");

  a_element_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_ADD || in_command == CMD_QUERY) && !in_last)
      |=> !out_valid)
    else $error("non-last element item produced a result");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_present) |-> (out_status == ST_OK))
    else $error("ranked match carries an error status");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_last_result)
    else $error("error status not the final result of its item");

  a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> out_valid)
    else $error("last marker without result strobe");
endmodule

bind cosine_topk_vector_index cvi_checker u_cvi_checker (.*);
`default_nettype wire
